// ----- hw/rtl/vgfpd_pkg.sv -----
// Shared types and constants for the voxel-grid first-point decimator.
// Used by vgfpd_axis, vgfpd_occ and voxel_grid_first_point_decimator_core.
// Depends on nothing.
`timescale 1ns / 1ps

package vgfpd_pkg;

    // Grid geometry.
    localparam int VOXELS_PER_AXIS = 16;
    localparam int CELL_W          = $clog2(VOXELS_PER_AXIS);

    // Field widths.
    localparam int COORD_W  = 32;
    localparam int TAG_W    = 32;
    localparam int IDX_W    = 12;

    // Occupancy bitmap, organised as rows of bits with one valid bit per row so
    // that all rows can be cleared together.
    localparam int OCC_DEPTH = 4096;
    localparam int ROW_W     = 16;
    localparam int BIT_AW    = $clog2(ROW_W);
    localparam int ROW_CNT   = OCC_DEPTH / ROW_W;
    localparam int ROW_AW    = $clog2(ROW_CNT);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z = 3'd5;

    localparam logic [COORD_W-1:0] MIN_RESET = 32'd0;
    localparam logic [COORD_W-1:0] INV_RESET = 32'd65536;

    // Test-and-set request issued with the row read.
    typedef struct packed {
        logic             valid;
        logic             new_node;
        logic [IDX_W-1:0] idx;
    } occ_req_t;

    // Outcome of the test-and-set, given in the cycle after the request.
    typedef struct packed {
        logic             valid;
        logic             keep;
        logic [IDX_W-1:0] idx;
    } occ_rsp_t;

endpackage

// ----- hw/rtl/vgfpd_axis.sv -----
// One axis of the voxel coordinate: offset from the bound, reciprocal multiply
// and clamp, over two register stages. Depends on vgfpd_pkg.
`timescale 1ns / 1ps

module vgfpd_axis
(
    input  logic                          clk,
    input  logic [vgfpd_pkg::COORD_W-1:0] pos,
    input  logic [vgfpd_pkg::COORD_W-1:0] min_val,
    input  logic [vgfpd_pkg::COORD_W-1:0] inv_val,
    output logic [vgfpd_pkg::CELL_W-1:0]  voxel
);

    localparam int W = vgfpd_pkg::COORD_W;

    logic signed [W:0]   diff;
    logic [W-1:0]        dpos_next;
    logic [W-1:0]        dpos_reg;
    logic [2*W-1:0]      prod;
    logic [W-1:0]        whole;
    logic [vgfpd_pkg::CELL_W-1:0] cell_next;
    logic [vgfpd_pkg::CELL_W-1:0] cell_reg;

    // The difference is exact in one extra bit; a non-positive one maps to voxel 0.
    assign diff      = $signed({pos[W-1], pos}) - $signed({min_val[W-1], min_val});
    assign dpos_next = diff[W] ? '0 : diff[W-1:0];

    assign prod  = dpos_reg * inv_val;
    assign whole = prod[2*W-1:W];

    always_comb
    begin
        if (whole > W'(vgfpd_pkg::VOXELS_PER_AXIS - 1))
            cell_next = vgfpd_pkg::CELL_W'(vgfpd_pkg::VOXELS_PER_AXIS - 1);
        else
            cell_next = whole[vgfpd_pkg::CELL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        dpos_reg <= dpos_next;
        cell_reg <= cell_next;
    end

    assign voxel = cell_reg;

endmodule

// ----- hw/rtl/vgfpd_occ.sv -----
// Occupancy bitmap with test-and-set: a row memory, one valid bit per row and
// forwarding of the previous write. Depends on vgfpd_pkg.
`timescale 1ns / 1ps

module vgfpd_occ
(
    input  logic                clk,
    input  logic                rst_n,
    input  vgfpd_pkg::occ_req_t req,
    output vgfpd_pkg::occ_rsp_t rsp
);

    localparam int ROW_W  = vgfpd_pkg::ROW_W;
    localparam int ROW_AW = vgfpd_pkg::ROW_AW;
    localparam int BIT_AW = vgfpd_pkg::BIT_AW;
    localparam int IDX_W  = vgfpd_pkg::IDX_W;

    logic [ROW_W-1:0]            mem [vgfpd_pkg::ROW_CNT];
    logic [ROW_W-1:0]            rd_data_reg;
    logic [vgfpd_pkg::ROW_CNT-1:0] row_valid_reg;
    logic [vgfpd_pkg::ROW_CNT-1:0] row_valid_next;

    logic                        valid_reg;
    logic                        new_node_reg;
    logic [IDX_W-1:0]            idx_reg;

    logic                        fwd_valid_reg;
    logic [IDX_W-1:0]            fwd_idx_reg;
    logic [ROW_W-1:0]            fwd_data_reg;

    logic [ROW_AW-1:0]           row;
    logic [BIT_AW-1:0]           bit_sel;
    logic [ROW_W-1:0]            base;
    logic [ROW_W-1:0]            new_row;
    logic                        fwd_hit;

    assign row     = idx_reg[IDX_W-1:BIT_AW];
    assign bit_sel = idx_reg[BIT_AW-1:0];

    // The row read misses only the write of the item just ahead, which is
    // forwarded. A new node starts from an empty row whatever is stored.
    assign fwd_hit = fwd_valid_reg && (fwd_idx_reg[IDX_W-1:BIT_AW] == row);

    always_comb
    begin
        if (new_node_reg)
            base = '0;
        else if (fwd_hit)
            base = fwd_data_reg;
        else if (row_valid_reg[row])
            base = rd_data_reg;
        else
            base = '0;
    end

    assign new_row = base | (ROW_W'(1) << bit_sel);

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (valid_reg)
        begin
            if (new_node_reg)
                row_valid_next = '0;
            row_valid_next[row] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
            mem[row] <= new_row;
        rd_data_reg <= mem[req.idx[IDX_W-1:BIT_AW]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            valid_reg     <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            valid_reg     <= req.valid;
            fwd_valid_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        new_node_reg <= req.new_node;
        idx_reg      <= req.idx;
        fwd_idx_reg  <= idx_reg;
        fwd_data_reg <= new_row;
    end

    assign rsp.valid = valid_reg;
    assign rsp.keep  = ~base[bit_sel];
    assign rsp.idx   = idx_reg;

    // A committed row is marked valid in the next cycle.
    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> row_valid_reg[$past(row)])
        else $error("committed occupancy row not marked valid");

    // Two consecutive points in the same voxel: the second is not kept unless it starts a new node.
    a_fwd_same_voxel: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !new_node_reg && fwd_valid_reg && (fwd_idx_reg == idx_reg)
        |-> !rsp.keep)
        else $error("forwarded occupancy bit lost");

    // A new node leaves exactly one occupied row behind.
    a_new_node_clear: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && new_node_reg |=> $onehot(row_valid_reg))
        else $error("new node did not clear occupancy rows");

endmodule

// ----- hw/rtl/voxel_grid_first_point_decimator_core.sv -----
// Top level of the voxel-grid first-point decimator: configuration registers,
// point pipeline, occupancy test-and-set and result queue.
// Depends on vgfpd_pkg, vgfpd_axis and vgfpd_occ.
//
//   Channel   Signals                                   Direction
//   --------  ----------------------------------------  ---------
//   points    in_valid/in_ready, pos_x/y/z, point_tag,   in
//             new_node
//   results   out_valid/out_ready, out_tag,              out
//             keep_for_lod, voxel_index
//   config    cfg_valid/cfg_ready, cfg_index, cfg_data   in
//
// One point per cycle while in_ready is high. The rate is set by the occupancy row
// read-modify-write, one row per cycle with the previous write forwarded. Up to
// eight points may be outstanding; when results are not taken the queue fills
// and in_ready falls. After reset the bitmap is empty at once (row valid bits),
// with no clearing pass.
`timescale 1ns / 1ps

module voxel_grid_first_point_decimator_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [vgfpd_pkg::COORD_W-1:0]     pos_x,
    input  logic [vgfpd_pkg::COORD_W-1:0]     pos_y,
    input  logic [vgfpd_pkg::COORD_W-1:0]     pos_z,
    input  logic [vgfpd_pkg::TAG_W-1:0]       point_tag,
    input  logic                              new_node,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vgfpd_pkg::TAG_W-1:0]       out_tag,
    output logic                              keep_for_lod,
    output logic [vgfpd_pkg::IDX_W-1:0]       voxel_index,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vgfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vgfpd_pkg::COORD_W-1:0]     cfg_data
);

    localparam int W        = vgfpd_pkg::COORD_W;
    localparam int TAG_W    = vgfpd_pkg::TAG_W;
    localparam int IDX_W    = vgfpd_pkg::IDX_W;
    localparam int CELL_W   = vgfpd_pkg::CELL_W;
    localparam int RES      = vgfpd_pkg::VOXELS_PER_AXIS;
    localparam int WIDE_W   = IDX_W + 3 * CELL_W;
    localparam int Q_DEPTH  = 8;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int CNT_W    = Q_AW + 1;

    // Configuration registers.
    logic [W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic [W-1:0] inv_x_reg, inv_y_reg, inv_z_reg;

    // Pipeline stages.
    logic             v1_reg, v2_reg, v3_reg;
    logic [W-1:0]     px1_reg, py1_reg, pz1_reg;
    logic [TAG_W-1:0] tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic             nn1_reg, nn2_reg, nn3_reg;

    logic [CELL_W-1:0] cell_x, cell_y, cell_z;
    logic [WIDE_W-1:0] lin;

    vgfpd_pkg::occ_req_t occ_req;
    vgfpd_pkg::occ_rsp_t occ_rsp;

    // Result queue.
    logic [TAG_W-1:0] q_tag  [Q_DEPTH];
    logic             q_keep [Q_DEPTH];
    logic [IDX_W-1:0] q_idx  [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] q_cnt_reg, q_cnt_next;
    logic [CNT_W-1:0] pend_reg, pend_next;

    logic in_xfer, out_xfer, push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= vgfpd_pkg::MIN_RESET;
            min_y_reg <= vgfpd_pkg::MIN_RESET;
            min_z_reg <= vgfpd_pkg::MIN_RESET;
            inv_x_reg <= vgfpd_pkg::INV_RESET;
            inv_y_reg <= vgfpd_pkg::INV_RESET;
            inv_z_reg <= vgfpd_pkg::INV_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vgfpd_pkg::CFG_MIN_X: min_x_reg <= cfg_data;
                vgfpd_pkg::CFG_MIN_Y: min_y_reg <= cfg_data;
                vgfpd_pkg::CFG_MIN_Z: min_z_reg <= cfg_data;
                vgfpd_pkg::CFG_INV_X: inv_x_reg <= cfg_data;
                vgfpd_pkg::CFG_INV_Y: inv_y_reg <= cfg_data;
                vgfpd_pkg::CFG_INV_Z: inv_z_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Every transfer reserves a queue slot, so the pipeline itself never stalls.
    assign in_ready = (pend_reg < CNT_W'(Q_DEPTH));
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign push     = occ_rsp.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px1_reg  <= pos_x;
        py1_reg  <= pos_y;
        pz1_reg  <= pos_z;
        tag1_reg <= point_tag;
        nn1_reg  <= new_node;
        tag2_reg <= tag1_reg;
        nn2_reg  <= nn1_reg;
        tag3_reg <= tag2_reg;
        nn3_reg  <= nn2_reg;
        tag4_reg <= tag3_reg;
    end

    vgfpd_axis u_axis_x
    (
        .clk     (clk),
        .pos     (px1_reg),
        .min_val (min_x_reg),
        .inv_val (inv_x_reg),
        .voxel   (cell_x)
    );

    vgfpd_axis u_axis_y
    (
        .clk     (clk),
        .pos     (py1_reg),
        .min_val (min_y_reg),
        .inv_val (inv_y_reg),
        .voxel   (cell_y)
    );

    vgfpd_axis u_axis_z
    (
        .clk     (clk),
        .pos     (pz1_reg),
        .min_val (min_z_reg),
        .inv_val (inv_z_reg),
        .voxel   (cell_z)
    );

    // The linear index wraps to the bitmap depth at larger resolutions.
    assign lin = WIDE_W'(cell_z) * WIDE_W'(RES * RES)
               + WIDE_W'(cell_y) * WIDE_W'(RES)
               + WIDE_W'(cell_x);

    assign occ_req.valid    = v3_reg;
    assign occ_req.new_node = nn3_reg;
    assign occ_req.idx      = lin[IDX_W-1:0];

    vgfpd_occ u_occ
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (occ_req),
        .rsp   (occ_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_tag[wr_ptr_reg]  <= tag4_reg;
            q_keep[wr_ptr_reg] <= occ_rsp.keep;
            q_idx[wr_ptr_reg]  <= occ_rsp.idx;
        end
    end

    assign q_cnt_next = q_cnt_reg + CNT_W'(push) - CNT_W'(out_xfer);
    assign pend_next  = pend_reg + CNT_W'(in_xfer) - CNT_W'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (out_xfer)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            q_cnt_reg <= q_cnt_next;
            pend_reg  <= pend_next;
        end
    end

    assign out_valid    = (q_cnt_reg != '0);
    assign out_tag      = q_tag[rd_ptr_reg];
    assign keep_for_lod = q_keep[rd_ptr_reg];
    assign voxel_index  = q_idx[rd_ptr_reg];

    // Outstanding points never exceed the queue, and the queue holds only
    // points already counted as outstanding.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg <= CNT_W'(Q_DEPTH)) && (q_cnt_reg <= pend_reg))
        else $error("outstanding count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !out_xfer |-> (q_cnt_reg < CNT_W'(Q_DEPTH)))
        else $error("result queue overflow");

    // A result on offer stays on offer, unchanged, until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_tag)
            && $stable(keep_for_lod) && $stable(voxel_index))
        else $error("result changed while waiting");

endmodule
